// ----- rtl/core/crc8fc_pkg.sv -----
// Shared constants, status codes and the CRC-8 byte update for the frame checker.
package crc8fc_pkg;

	localparam int unsigned PosW = 9;

	localparam logic [PosW-1:0] PosSat   = 9'd260;
	localparam logic [PosW-1:0] PosCmd   = 9'd2;
	localparam logic [PosW-1:0] PosLen   = 9'd3;
	localparam logic [PosW-1:0] HdrBytes = 9'd4;
	localparam logic [PosW-1:0] MinBytes = 9'd5;

	localparam logic [7:0] SyncByte = 8'h55;
	localparam logic [7:0] CrcPoly  = 8'h07;
	localparam logic [7:0] CrcInit  = 8'hFF;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_TOO_SHORT = 3'd1,
		ST_BAD_HDR   = 3'd2,
		ST_TRUNCATED = 3'd3,
		ST_CRC_BAD   = 3'd4
	} frame_status_t;

	// CRC-8, MSB first, no reflection, one byte per call
	function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CrcPoly;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ----- rtl/core/crc8_frame_checker.sv -----
// Top level of the length-prefixed CRC-8 frame checker.
//
//  channel   handshake              payload
//  -------   ---------------------  -------------------------------------
//  input     in_valid / in_ready    data_byte[7:0], last_byte
//  output    out_valid / out_ready  status[2:0], command[7:0], payload_length[7:0]
//
// One byte per cycle while in_ready is high. The frame state (position,
// running CRC, captured header fields) is updated in the cycle a request is
// taken; its CRC update is the longest path between the state registers.
// A request with last_byte loads the result register and clears the frame state.
// arst_n clears the frame state and out_valid, not the result payload. The result
// register holds while out_ready is low; a byte is then taken only if it is empty.
module crc8_frame_checker (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [7:0]             data_byte,
	input  logic                   last_byte,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [2:0]             status,
	output logic [7:0]             command,
	output logic [7:0]             payload_length
);
	import crc8fc_pkg::*;

	// frame state
	logic [PosW-1:0]  pos_q;
	logic [7:0]       crc_q;
	logic             hdr_ok_q;
	logic [7:0]       cmd_q;
	logic [7:0]       len_q;
	logic             match_q;

	// result register
	logic             out_valid_q;
	frame_status_t    status_q;
	logic [7:0]       cmd_out_q;
	logic [7:0]       len_out_q;

	logic             in_take;
	logic [PosW-1:0]  pos_nx;
	logic [7:0]       crc_nx;
	logic             hdr_ok_nx;
	logic [7:0]       cmd_nx;
	logic [7:0]       len_nx;
	logic             match_nx;
	logic [PosW-1:0]  crc_end;
	frame_status_t    status_nx;

	assign in_ready = !out_valid_q || out_ready;
	assign in_take  = in_valid && in_ready;

	// per-byte state update
	always_comb begin
		hdr_ok_nx = hdr_ok_q;
		cmd_nx    = cmd_q;
		len_nx    = len_q;
		crc_nx    = crc_q;
		match_nx  = match_q;
		if (pos_q == '0) begin
			hdr_ok_nx = (data_byte == SyncByte);
		end
		if (pos_q == PosCmd) begin
			cmd_nx = data_byte;
		end
		if (pos_q == PosLen) begin
			len_nx = data_byte;
		end
		crc_end = HdrBytes + {1'b0, len_nx};
		if (pos_q < crc_end) begin
			crc_nx = crc8_next(crc_q, data_byte);
		end else if (pos_q == crc_end) begin
			match_nx = (data_byte == crc_q);
		end
		pos_nx = (pos_q < PosSat) ? pos_q + 1'b1 : pos_q;
	end

	// end-of-frame verdict, first failing check wins
	always_comb begin
		if (pos_nx < MinBytes) begin
			status_nx = ST_TOO_SHORT;
		end else if (!hdr_ok_nx) begin
			status_nx = ST_BAD_HDR;
		end else if (pos_nx < MinBytes + {1'b0, len_nx}) begin
			status_nx = ST_TRUNCATED;
		end else if (!match_nx) begin
			status_nx = ST_CRC_BAD;
		end else begin
			status_nx = ST_OK;
		end
	end

	// frame state registers; cleared after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			crc_q    <= CrcInit;
			hdr_ok_q <= 1'b0;
			cmd_q    <= '0;
			len_q    <= '0;
			match_q  <= 1'b0;
		end else if (in_take) begin
			if (last_byte) begin
				pos_q    <= '0;
				crc_q    <= CrcInit;
				hdr_ok_q <= 1'b0;
				cmd_q    <= '0;
				len_q    <= '0;
				match_q  <= 1'b0;
			end else begin
				pos_q    <= pos_nx;
				crc_q    <= crc_nx;
				hdr_ok_q <= hdr_ok_nx;
				cmd_q    <= cmd_nx;
				len_q    <= len_nx;
				match_q  <= match_nx;
			end
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_take && last_byte) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (in_take && last_byte) begin
			status_q  <= status_nx;
			cmd_out_q <= cmd_nx;
			len_out_q <= len_nx;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign command        = cmd_out_q;
	assign payload_length = len_out_q;

	// frame state is back at reset after the final byte
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(in_take && last_byte) |=> (pos_q == '0 && crc_q == CrcInit && !hdr_ok_q))
		else $error("frame state not cleared after final byte");

	// a result only appears from a final byte
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(in_take && last_byte))
		else $error("result raised without a final byte");

	// position never passes saturation
	a_pos_sat: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= PosSat)
		else $error("byte position beyond saturation");

	// an ok verdict needs the header flag of the frame that ended
	a_ok_needs_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		(in_take && last_byte && status_nx == ST_OK) |-> hdr_ok_nx)
		else $error("ok verdict without a valid header");

endmodule

// ----- sim/crc8_frame_checker_tb.sv -----
// Self-checking testbench for the CRC-8 frame checker: directed frames, then random traffic.
`timescale 1ns / 100ps

module crc8_frame_checker_tb;
	import crc8fc_pkg::*;

	localparam int CycLimit = 200000;
	localparam int TailCycles = 16;

	typedef struct packed {
		frame_status_t status;
		logic [7:0]    command;
		logic [7:0]    plen;
	} frame_result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] data_byte = 8'h00;
	logic       last_byte = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [2:0] status;
	logic [7:0] command;
	logic [7:0] payload_length;

	// results still owed by the block, oldest first
	frame_result_t result_q[$];
	// bytes of the frame under construction
	logic [7:0]    frm_bytes[$];

	int  n_fail = 0;
	int  cyc = 0;
	bit  steady = 1'b0;

	// shadow of the checker's frame state
	logic [8:0] fp_pos;
	logic [7:0] fp_crc;
	logic       fp_hdr_ok;
	logic [7:0] fp_cmd;
	logic [7:0] fp_len;
	logic       fp_crc_ok;

	crc8_frame_checker u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.data_byte      (data_byte),
		.last_byte      (last_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.command        (command),
		.payload_length (payload_length)
	);

	always #2 clk = ~clk;

	// run guard
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc >= CycLimit) begin
			$display("tb: failure");
			$finish;
		end
	end

	// receiver back-pressure, switched off during the steady stretch
	always @(posedge clk) begin
		out_ready <= steady || ($urandom_range(99) >= 19);
	end

	// CRC-8, poly 0x07, MSB first
	function automatic logic [7:0] crc8_add(input logic [7:0] acc, input logic [7:0] b);
		logic [7:0] r;
		r = acc ^ b;
		repeat (8) r = r[7] ? ((r << 1) ^ CrcPoly) : (r << 1);
		return r;
	endfunction

	function automatic void tracker_clear();
		fp_pos    = '0;
		fp_crc    = CrcInit;
		fp_hdr_ok = 1'b0;
		fp_cmd    = 8'h00;
		fp_len    = 8'h00;
		fp_crc_ok = 1'b0;
	endfunction

	// advance the shadow state by one accepted byte; queue a result on the final one
	function automatic void track_byte(input logic [7:0] b, input logic fin);
		frame_result_t r;
		if (fp_pos == '0)
			fp_hdr_ok = (b == SyncByte);
		if (fp_pos == PosCmd)
			fp_cmd = b;
		if (fp_pos == PosLen)
			fp_len = b;
		if (fp_pos < HdrBytes + fp_len)
			fp_crc = crc8_add(fp_crc, b);
		else if (fp_pos == HdrBytes + fp_len)
			fp_crc_ok = (b == fp_crc);
		if (fp_pos < PosSat)
			fp_pos = fp_pos + 1'b1;
		if (fin) begin
			if (fp_pos < MinBytes)
				r.status = ST_TOO_SHORT;
			else if (!fp_hdr_ok)
				r.status = ST_BAD_HDR;
			else if (fp_pos < MinBytes + fp_len)
				r.status = ST_TRUNCATED;
			else if (!fp_crc_ok)
				r.status = ST_CRC_BAD;
			else
				r.status = ST_OK;
			r.command = fp_cmd;
			r.plen    = fp_len;
			result_q.push_back(r);
			tracker_clear();
		end
	endfunction

	// result checker
	always @(posedge clk) begin
		frame_result_t e;
		if (arst_n && out_valid && out_ready) begin
			if (result_q.size() == 0) begin
				$error("unexpected result: status %0d command %0h payload_length %0h",
					status, command, payload_length);
				n_fail++;
			end else begin
				e = result_q.pop_front();
				if (status !== e.status) begin
					$error("status: expected %0d, got %0d", e.status, status);
					n_fail++;
				end
				if (command !== e.command) begin
					$error("command: expected %0h, got %0h", e.command, command);
					n_fail++;
				end
				if (payload_length !== e.plen) begin
					$error("payload_length: expected %0h, got %0h", e.plen, payload_length);
					n_fail++;
				end
			end
		end
	end

	// one request on the input channel, with occasional idle cycles first
	task automatic send_byte(input logic [7:0] b, input logic fin);
		while (!steady && $urandom_range(99) < 19) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		last_byte <= fin;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		track_byte(b, fin);
	endtask

	task automatic send_frame();
		foreach (frm_bytes[i])
			send_byte(frm_bytes[i], i == frm_bytes.size() - 1);
	endtask

	// sync, version, cmd, len, random payload, crc (optionally corrupted), trailing junk
	task automatic make_frame(input logic [7:0] sync, input logic [7:0] ver,
			input logic [7:0] cmd, input logic [7:0] len, input bit crc_bad, input int n_trail);
		logic [7:0] c;
		frm_bytes.delete();
		frm_bytes.push_back(sync);
		frm_bytes.push_back(ver);
		frm_bytes.push_back(cmd);
		frm_bytes.push_back(len);
		repeat (len) frm_bytes.push_back(8'($urandom));
		c = CrcInit;
		foreach (frm_bytes[i])
			c = crc8_add(c, frm_bytes[i]);
		if (crc_bad)
			c = c ^ (8'h01 << $urandom_range(7));
		frm_bytes.push_back(c);
		repeat (n_trail) frm_bytes.push_back(8'($urandom));
	endtask

	// hold off the sender until every owed result is out
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (result_q.size() != 0) @(posedge clk);
	endtask

	task automatic test_good_minimal();
		make_frame(SyncByte, 8'hFF, 8'h00, 8'h00, 1'b0, 0);
		send_frame();
	endtask

	task automatic test_short_frames();
		// lone sync byte, nothing captured
		frm_bytes = '{SyncByte};
		send_frame();
		// header only, cmd and len captured but no crc
		frm_bytes = '{SyncByte, 8'h00, 8'hA5, 8'h03};
		send_frame();
	endtask

	task automatic test_bad_header();
		make_frame(8'hAA, 8'h12, 8'hFF, 8'h00, 1'b0, 0);
		send_frame();
	endtask

	task automatic test_truncated();
		frm_bytes = '{SyncByte, 8'h01, 8'h10, 8'h02, 8'h33};
		send_frame();
	endtask

	task automatic test_crc_mismatch();
		make_frame(SyncByte, 8'h00, 8'h7E, 8'h00, 1'b1, 0);
		send_frame();
	endtask

	task automatic test_trailing_bytes();
		make_frame(SyncByte, 8'h80, 8'h01, 8'h00, 1'b0, 1);
		frm_bytes[frm_bytes.size() - 1] = 8'hFF;
		send_frame();
	endtask

	// longest payload, run past the position saturation point
	task automatic test_long_buffer();
		make_frame(SyncByte, 8'h00, 8'hFF, 8'hFF, 1'b0, 12);
		send_frame();
	endtask

	// mostly well-formed frames, the rest corrupted, cut short or noise
	task automatic test_random_frames(input int n_bytes, input bit pause_midway);
		int sent;
		int kind;
		int len;
		int keep;
		bit paused;
		sent = 0;
		paused = 1'b0;
		while (sent < n_bytes) begin
			kind = $urandom_range(99);
			len = ($urandom_range(9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
			make_frame(SyncByte, 8'($urandom), 8'($urandom), 8'(len),
				kind >= 62 && kind < 74,
				($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0);
			if (kind >= 74 && kind < 85) begin
				keep = $urandom_range(1, frm_bytes.size() - 1);
				while (frm_bytes.size() > keep) void'(frm_bytes.pop_back());
			end else if (kind >= 85 && kind < 93) begin
				frm_bytes[0] = 8'($urandom);
			end else if (kind >= 93) begin
				frm_bytes.delete();
				repeat ($urandom_range(1, 8)) frm_bytes.push_back(8'($urandom));
			end
			sent += frm_bytes.size();
			send_frame();
			if (pause_midway && !paused && sent >= n_bytes / 2) begin
				drain_results();
				paused = 1'b1;
			end
		end
	endtask

	// no gaps on either side
	task automatic test_back_to_back(input int n_bytes);
		steady = 1'b1;
		test_random_frames(n_bytes, 1'b0);
		steady = 1'b0;
	endtask

	initial begin
		tracker_clear();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_good_minimal();
		test_short_frames();
		test_bad_header();
		test_truncated();
		test_crc_mismatch();
		test_trailing_bytes();
		test_long_buffer();
		test_random_frames(520, 1'b1);
		test_back_to_back(160);

		// let the last results through
		in_valid <= 1'b0;
		while (result_q.size() != 0) @(posedge clk);
		repeat (TailCycles) @(posedge clk);
		if (n_fail == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ----- crc8_frame_checker.f -----
rtl/core/crc8fc_pkg.sv
rtl/core/crc8_frame_checker.sv
sim/crc8_frame_checker_tb.sv
